@@ rtl/core/vxh_pkg.sv @@
package vxh_pkg;

  localparam int GRID_CELLS_DEFAULT = 160;
  localparam int COUNT_BITS_DEFAULT = 16;

  // index width that covers every supported grid size
  localparam int IDX_BITS = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_BITS = 5;

  typedef struct packed {
    logic        func;
    logic [23:0] point_x;
    logic [23:0] point_y;
    logic [23:0] point_z;
    logic [7:0]  read_row;
    logic [7:0]  read_col;
  } request_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [15:0] cell_count;
    logic        occupied;
  } result_t;

  typedef struct packed {
    logic [8:0]  exclude_x_low;
    logic [8:0]  exclude_x_high;
    logic [8:0]  exclude_y_low;
    logic [8:0]  exclude_y_high;
    logic [7:0]  height_low;
    logic [7:0]  height_high;
    logic [15:0] count_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    exclude_x_low:   9'h1fb,
    exclude_x_high:  9'd5,
    exclude_y_low:   9'h1fd,
    exclude_y_high:  9'd3,
    height_low:      8'd0,
    height_high:     8'd6,
    count_threshold: 16'd5
  };

  typedef enum logic [2:0] {
    REG_EXCLUDE_X_LOW   = 3'd0,
    REG_EXCLUDE_X_HIGH  = 3'd1,
    REG_EXCLUDE_Y_LOW   = 3'd2,
    REG_EXCLUDE_Y_HIGH  = 3'd3,
    REG_HEIGHT_LOW      = 3'd4,
    REG_HEIGHT_HIGH     = 3'd5,
    REG_COUNT_THRESHOLD = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_COUNT,
    KIND_REJECT,
    KIND_READ,
    KIND_READ_MISS
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } job_t;

endpackage

@@ rtl/core/vxh_front.sv @@
module vxh_front import vxh_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
  input  logic     in_valid,
  output logic     in_ready,
  input  request_t in_req,
  input  cfg_t     cfg,
  input  logic     q_full,
  input  logic     clearing,
  output logic     push,
  output job_t     push_job
);

  localparam logic signed [19:0] GRID_HI = 20'(GRID_CELLS);
  localparam logic signed [19:0] GRID_LO = -GRID_HI;
  localparam int HALF = GRID_CELLS / 2;
  localparam logic [6:0] ROUND_HALF = 7'd64;

  // round half to even, 1/256 m to half-metre voxels
  function automatic logic signed [17:0] to_voxel(input logic [23:0] c);
    logic signed [17:0] fl;
    logic [6:0] rem;
    logic up;
    fl = signed'({c[23], c[23:7]});
    rem = c[6:0];
    up = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && fl[0]);
    return fl + 18'(up);
  endfunction

  function automatic logic in_grid(input logic signed [17:0] v);
    logic signed [19:0] x2;
    x2 = signed'({v[17], v, 1'b0});
    return (x2 > GRID_LO) && (x2 < GRID_HI);
  endfunction

  logic signed [17:0] vx, vy, vz;
  logic signed [17:0] xl, xh, yl, yh, hl, hh;
  logic in_bounds, boxed, keep, rd_ok;
  logic [17:0] row_full, col_full;

  assign vx = to_voxel(in_req.point_x);
  assign vy = to_voxel(in_req.point_y);
  assign vz = to_voxel(in_req.point_z);

  assign xl = 18'(signed'(cfg.exclude_x_low));
  assign xh = 18'(signed'(cfg.exclude_x_high));
  assign yl = 18'(signed'(cfg.exclude_y_low));
  assign yh = 18'(signed'(cfg.exclude_y_high));
  assign hl = 18'(signed'(cfg.height_low));
  assign hh = 18'(signed'(cfg.height_high));

  assign in_bounds = in_grid(vx) && in_grid(vy) && (vz > hl) && (vz < hh);
  assign boxed = (vx > xl) && (vx < xh) && (vy > yl) && (vy < yh);
  assign keep = in_bounds && !boxed;

  assign row_full = vx + 18'(HALF);
  assign col_full = vy + 18'(HALF);

  assign rd_ok = (11'(in_req.read_row) < 11'(GRID_CELLS))
              && (11'(in_req.read_col) < 11'(GRID_CELLS));

  assign in_ready = !q_full && !clearing;
  assign push = in_valid && in_ready;

  always_comb begin
    push_job = '0;
    if (in_req.func) begin
      push_job.kind = rd_ok ? KIND_READ : KIND_READ_MISS;
      push_job.row = IDX_BITS'(in_req.read_row);
      push_job.col = IDX_BITS'(in_req.read_col);
    end else if (keep) begin
      push_job.kind = KIND_COUNT;
      push_job.row = row_full[IDX_BITS-1:0];
      push_job.col = col_full[IDX_BITS-1:0];
    end else begin
      push_job.kind = KIND_REJECT;
    end
  end

endmodule

@@ rtl/core/vxh_queue.sv @@
module vxh_queue import vxh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_job = slots[rd_ptr];

  function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

@@ rtl/core/vxh_back.sv @@
module vxh_back import vxh_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        clearing,
  input  logic [15:0] threshold,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_rsp
);

  localparam int CELLS = GRID_CELLS * GRID_CELLS;
  localparam int ADDR_BITS = $clog2(CELLS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW
  } state_t;

  state_t state;
  logic [ADDR_BITS-1:0] clr_addr, cur_addr, q_addr, mem_waddr;
  job_t cur;
  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [COUNT_BITS-1:0] rdata, bumped, mem_wdata;
  logic mem_we, out_free, finish;
  result_t rsp;

  assign q_addr = ADDR_BITS'(q_job.row) * ADDR_BITS'(GRID_CELLS) + ADDR_BITS'(q_job.col);
  assign clearing = (state == S_CLEAR);
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || out_ready;
  assign finish = (state == S_RMW) && out_free;
  assign bumped = (rdata == CNT_MAX) ? rdata : rdata + COUNT_BITS'(1);

  always_comb begin
    rsp = '0;
    unique case (cur.kind)
      KIND_COUNT: begin
        rsp.accepted = 1'b1;
        rsp.cell_row = 8'(cur.row);
        rsp.cell_col = 8'(cur.col);
        rsp.cell_count = 16'(bumped);
        rsp.occupied = 32'(bumped) > 32'(threshold);
      end
      KIND_REJECT: begin
      end
      KIND_READ: begin
        rsp.cell_row = 8'(cur.row);
        rsp.cell_col = 8'(cur.col);
        rsp.cell_count = 16'(rdata);
        rsp.occupied = 32'(rdata) > 32'(threshold);
      end
      KIND_READ_MISS: begin
        rsp.cell_row = 8'(cur.row);
        rsp.cell_col = 8'(cur.col);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
    end else if (finish) begin
      if (cur.kind == KIND_COUNT) begin
        mem_we = 1'b1;
        mem_wdata = bumped;
      end else if (cur.kind == KIND_READ) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rdata <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_addr == ADDR_BITS'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_job;
            cur_addr <= q_addr;
            state <= S_RMW;
          end
        end
        S_RMW: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        out_valid <= 1'b1;
        out_rsp <= rsp;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/point_cloud_voxel_histogram.sv @@
// Occupancy grid binning of lidar points. A request with func 0 rounds x, y, z (1/256 m)
// to half-metre voxels, filters them against the grid, the height band and the vehicle
// exclusion box, and bumps the saturating counter of the cell; func 1 returns one cell's
// count and clears it. Every request gives exactly one result. The front classifies one
// request per cycle, while the queue is not full and no clear runs, into a two-entry
// queue; the counter stage reads then writes the single-port count memory for a request
// and passes on its result before it pops the next one. After reset the memory is zeroed
// one cell per cycle over all GRID_CELLS*GRID_CELLS cells (25600 at the default size),
// and in_ready stays low until that pass is done; APB registers can be written at any time.
module point_cloud_voxel_histogram import vxh_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  request_t              in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  reg_idx_t reg_idx;
  logic q_push, q_full, q_pop, q_empty, clearing;
  job_t push_job, pop_job;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_EXCLUDE_X_LOW:   cfg.exclude_x_low <= pwdata[8:0];
        REG_EXCLUDE_X_HIGH:  cfg.exclude_x_high <= pwdata[8:0];
        REG_EXCLUDE_Y_LOW:   cfg.exclude_y_low <= pwdata[8:0];
        REG_EXCLUDE_Y_HIGH:  cfg.exclude_y_high <= pwdata[8:0];
        REG_HEIGHT_LOW:      cfg.height_low <= pwdata[7:0];
        REG_HEIGHT_HIGH:     cfg.height_high <= pwdata[7:0];
        REG_COUNT_THRESHOLD: cfg.count_threshold <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXCLUDE_X_LOW:   prdata = 32'(cfg.exclude_x_low);
      REG_EXCLUDE_X_HIGH:  prdata = 32'(cfg.exclude_x_high);
      REG_EXCLUDE_Y_LOW:   prdata = 32'(cfg.exclude_y_low);
      REG_EXCLUDE_Y_HIGH:  prdata = 32'(cfg.exclude_y_high);
      REG_HEIGHT_LOW:      prdata = 32'(cfg.height_low);
      REG_HEIGHT_HIGH:     prdata = 32'(cfg.height_high);
      REG_COUNT_THRESHOLD: prdata = 32'(cfg.count_threshold);
      default:             prdata = '0;
    endcase
  end

  vxh_front #(
    .GRID_CELLS(GRID_CELLS)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .cfg(cfg),
    .q_full(q_full),
    .clearing(clearing),
    .push(q_push),
    .push_job(push_job)
  );

  vxh_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(push_job),
    .full(q_full),
    .pop(q_pop),
    .pop_job(pop_job),
    .empty(q_empty)
  );

  vxh_back #(
    .GRID_CELLS(GRID_CELLS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_job(pop_job),
    .q_pop(q_pop),
    .clearing(clearing),
    .threshold(cfg.count_threshold),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp)
  );

`ifndef SYNTH
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request taken during memory clear");

  a_clear_runs_once: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(clearing)) |-> !clearing)
    else $error("memory clear restarted without reset");

  a_counted_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.accepted) |->
      (32'(out_rsp.cell_row) < GRID_CELLS) && (32'(out_rsp.cell_col) < GRID_CELLS))
    else $error("counted cell outside grid");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop && !out_valid)
    else $error("counter stage active during memory clear");
`endif

endmodule

@@ sim/tb_point_cloud_voxel_histogram.sv @@
`timescale 1ns / 100ps

module tb_point_cloud_voxel_histogram;
  import vxh_pkg::*;

  localparam int GRID = GRID_CELLS_DEFAULT;
  localparam int HALF = GRID / 2;
  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam logic FUNC_POINT = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  request_t              in_req;
  logic                  out_valid;
  logic                  out_ready;
  result_t               out_rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  cfg_t        cfg_model;
  logic [15:0] cell_model [0:GRID*GRID-1];
  result_t     expected_results [$];
  int          mismatch_count;
  int          stall_cycles;
  bit          idling_on;
  bit          hold_off_req;
  bit          hold_off_done;

  point_cloud_voxel_histogram i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // round to half-metre voxel, ties to even
  function automatic int voxel_of(logic [23:0] coord);
    int fl;
    logic [6:0] rem;
    fl = int'($signed(coord)) >>> 7;
    rem = coord[6:0];
    if (rem > 7'd64) begin
      fl = fl + 1;
    end else if (rem == 7'd64 && (fl & 1) != 0) begin
      fl = fl + 1;
    end
    return fl;
  endfunction

  function automatic result_t predict_result(request_t req);
    result_t     res;
    int          vx, vy, vz, idx;
    int          xl, xh, yl, yh, hl, hh;
    logic [15:0] cnt;
    bit          in_bounds, boxed;
    res = '0;
    if (req.func == FUNC_READ) begin
      res.cell_row = req.read_row;
      res.cell_col = req.read_col;
      if (int'(req.read_row) < GRID && int'(req.read_col) < GRID) begin
        idx = int'(req.read_row) * GRID + int'(req.read_col);
        cnt = cell_model[idx];
        cell_model[idx] = '0;
        res.cell_count = cnt;
        res.occupied = cnt > cfg_model.count_threshold;
      end
      return res;
    end
    vx = voxel_of(req.point_x);
    vy = voxel_of(req.point_y);
    vz = voxel_of(req.point_z);
    xl = int'($signed(cfg_model.exclude_x_low));
    xh = int'($signed(cfg_model.exclude_x_high));
    yl = int'($signed(cfg_model.exclude_y_low));
    yh = int'($signed(cfg_model.exclude_y_high));
    hl = int'($signed(cfg_model.height_low));
    hh = int'($signed(cfg_model.height_high));
    in_bounds = (2 * vx > -GRID) && (2 * vx < GRID) && (2 * vy > -GRID) && (2 * vy < GRID)
                && vz > hl && vz < hh;
    boxed = vx > xl && vx < xh && vy > yl && vy < yh;
    if (in_bounds && !boxed) begin
      idx = (vx + HALF) * GRID + (vy + HALF);
      cnt = cell_model[idx];
      if (cnt != COUNT_MAX) begin
        cnt = cnt + 16'd1;
      end
      cell_model[idx] = cnt;
      res.accepted = 1'b1;
      res.cell_row = 8'(vx + HALF);
      res.cell_col = 8'(vy + HALF);
      res.cell_count = cnt;
      res.occupied = cnt > cfg_model.count_threshold;
    end
    return res;
  endfunction

  function automatic request_t make_point(int cx, int cy, int cz);
    request_t req;
    req.func = FUNC_POINT;
    req.point_x = cx[23:0];
    req.point_y = cy[23:0];
    req.point_z = cz[23:0];
    req.read_row = 8'($urandom);
    req.read_col = 8'($urandom);
    return req;
  endfunction

  function automatic request_t make_voxel_point(int vx, int vy, int vz);
    return make_point(vx * 128, vy * 128, vz * 128);
  endfunction

  function automatic request_t make_read(int row, int col);
    request_t req;
    req.func = FUNC_READ;
    req.point_x = 24'($urandom);
    req.point_y = 24'($urandom);
    req.point_z = 24'($urandom);
    req.read_row = row[7:0];
    req.read_col = col[7:0];
    return req;
  endfunction

  function automatic request_t random_request();
    int vx, vy, vz, hl, hh, span, pick, row, col;
    hl = int'($signed(cfg_model.height_low));
    hh = int'($signed(cfg_model.height_high));
    span = hh - hl + 2;
    if (span < 2 || span > 12) begin
      span = 6;
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        row = HALF - 12 + $urandom_range(0, 24);
        col = HALF - 12 + $urandom_range(0, 24);
      end else if (pick < 95) begin
        row = $urandom_range(0, GRID - 1);
        col = $urandom_range(0, GRID - 1);
      end else begin
        row = $urandom_range(0, 255);
        col = $urandom_range(GRID, 255);
      end
      return make_read(row, col);
    end
    if (pick < 85) begin
      vx = int'($urandom_range(0, 24)) - 12;
      vy = int'($urandom_range(0, 24)) - 12;
    end else if (pick < 93) begin
      vx = ($urandom_range(0, 1) != 0) ? int'($urandom_range(77, 81))
                                        : -int'($urandom_range(77, 81));
      vy = ($urandom_range(0, 1) != 0) ? int'($urandom_range(77, 81))
                                        : -int'($urandom_range(77, 81));
    end else begin
      return make_point(int'($urandom), int'($urandom), int'($urandom));
    end
    vz = hl - 1 + int'($urandom_range(0, span));
    return make_point(vx * 128 + int'($urandom_range(0, 127)) - 64,
                      vy * 128 + int'($urandom_range(0, 127)) - 64,
                      vz * 128 + int'($urandom_range(0, 127)) - 64);
  endfunction

  task automatic send_request(request_t req);
    int gap;
    result_t want;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    want = predict_result(req);
    expected_results = {expected_results, want};
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_EXCLUDE_X_LOW:   cfg_model.exclude_x_low = value[8:0];
      REG_EXCLUDE_X_HIGH:  cfg_model.exclude_x_high = value[8:0];
      REG_EXCLUDE_Y_LOW:   cfg_model.exclude_y_low = value[8:0];
      REG_EXCLUDE_Y_HIGH:  cfg_model.exclude_y_high = value[8:0];
      REG_HEIGHT_LOW:      cfg_model.height_low = value[7:0];
      REG_HEIGHT_HIGH:     cfg_model.height_high = value[7:0];
      REG_COUNT_THRESHOLD: cfg_model.count_threshold = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(int xl, int xh, int yl, int yh, int hl, int hh, int thr);
    wait_idle();
    write_register(REG_EXCLUDE_X_LOW, xl);
    write_register(REG_EXCLUDE_X_HIGH, xh);
    write_register(REG_EXCLUDE_Y_LOW, yl);
    write_register(REG_EXCLUDE_Y_HIGH, yh);
    write_register(REG_HEIGHT_LOW, hl);
    write_register(REG_HEIGHT_HIGH, hh);
    write_register(REG_COUNT_THRESHOLD, thr);
  endtask

  task automatic test_directed();
    // reset settings: box x -5..5, y -3..3, band 0..6, threshold 5
    send_request(make_voxel_point(10, 10, 2));
    send_request(make_voxel_point(10, 10, 2));
    // rounding ties and near-ties
    send_request(make_point(10 * 128 + 64, 1280, 256));
    send_request(make_point(11 * 128 + 64, 1280, 256));
    send_request(make_point(10 * 128 + 65, 1280, 256));
    send_request(make_point(10 * 128 + 63, 1280, 256));
    send_request(make_point(-10 * 128 - 64, -1280 - 64, 256 + 64));
    // grid edges
    send_request(make_voxel_point(79, 79, 3));
    send_request(make_voxel_point(80, 0, 3));
    send_request(make_voxel_point(-79, -79, 3));
    send_request(make_voxel_point(-80, 20, 3));
    send_request(make_voxel_point(20, -80, 3));
    send_request(make_point(24'h7fffff, 24'h800000, 24'h7fffff));
    send_request(make_point(24'h800000, 24'h7fffff, 24'h800000));
    // height band edges
    send_request(make_voxel_point(10, 10, 0));
    send_request(make_voxel_point(10, 10, 1));
    send_request(make_voxel_point(10, 10, 5));
    send_request(make_voxel_point(10, 10, 6));
    // exclusion box edges
    send_request(make_voxel_point(0, 0, 2));
    send_request(make_voxel_point(5, 0, 2));
    send_request(make_voxel_point(4, 2, 2));
    send_request(make_voxel_point(4, 3, 2));
    // reads, repeated read, out of range reads
    send_request(make_read(HALF + 10, HALF + 10));
    send_request(make_read(HALF + 10, HALF + 10));
    send_request(make_read(GRID - 1, GRID - 1));
    send_request(make_read(0, GRID - 1));
    send_request(make_read(GRID, 0));
    send_request(make_read(255, 255));
  endtask

  task automatic test_count_threshold();
    apply_settings(-5, 5, -3, 3, 0, 6, 10);
    repeat (12) send_request(make_voxel_point(-20, 30, 2));
    send_request(make_read(HALF - 20, HALF + 30));
    send_request(make_read(HALF - 20, HALF + 30));
    apply_settings(-5, 5, -3, 3, 0, 6, 0);
    send_request(make_voxel_point(-20, 30, 2));
    send_request(make_read(HALF - 20, HALF + 30));
  endtask

  task automatic test_empty_band_and_box();
    apply_settings(-5, 5, -3, 3, 3, 3, 1);
    send_request(make_voxel_point(10, 10, 3));
    send_request(make_voxel_point(10, 10, 2));
    apply_settings(-5, 5, -3, 3, 64, -64, 1);
    send_request(make_voxel_point(10, 10, 0));
    // box with low above high excludes nothing
    apply_settings(5, -5, -3, 3, -64, 64, 1);
    send_request(make_voxel_point(0, 0, -63));
    send_request(make_voxel_point(0, 0, 63));
    send_request(make_voxel_point(0, 0, 64));
    send_request(make_read(HALF, HALF));
    // box over the whole grid
    apply_settings(-160, 160, -160, 160, -64, 64, 65535);
    send_request(make_voxel_point(79, -79, 0));
    send_request(make_voxel_point(0, 0, 0));
    apply_settings(-160, 160, 160, -160, -64, 64, 65535);
    send_request(make_voxel_point(79, -79, 0));
    send_request(make_read(GRID - 1, 1));
  endtask

  task automatic random_settings();
    int xl, xh, yl, yh, hl, hh;
    xl = int'($urandom_range(0, 12)) - 8;
    xh = xl + int'($urandom_range(0, 12)) - 2;
    yl = int'($urandom_range(0, 12)) - 8;
    yh = yl + int'($urandom_range(0, 12)) - 2;
    hl = int'($urandom_range(0, 6)) - 3;
    hh = hl + int'($urandom_range(1, 7));
    apply_settings(xl, xh, yl, yh, hl, hh, $urandom_range(0, 6));
  endtask

  task automatic test_backpressure();
    apply_settings(-5, 5, -3, 3, 0, 6, 5);
    hold_off_req = 1'b1;
    repeat (40) send_request(random_request());
  endtask

  task automatic test_random_phases();
    repeat (4) begin
      random_settings();
      repeat (250) send_request(random_request());
    end
  endtask

  task automatic test_random_no_idle();
    random_settings();
    idling_on = 1'b0;
    repeat (200) send_request(random_request());
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
        out_ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", 16'(want.accepted), 16'(out_rsp.accepted));
        check_field("cell_row", 16'(want.cell_row), 16'(out_rsp.cell_row));
        check_field("cell_col", 16'(want.cell_col), 16'(out_rsp.cell_col));
        check_field("cell_count", want.cell_count, out_rsp.cell_count);
        check_field("occupied", 16'(want.occupied), 16'(out_rsp.occupied));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_model = CFG_RESET;
    idling_on = 1'b1;
    hold_off_req = 1'b0;
    for (int i = 0; i < GRID * GRID; i++) begin
      cell_model[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_count_threshold();
    test_empty_band_and_box();
    test_backpressure();
    test_random_phases();
    test_random_no_idle();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
